>>> rtl/periodic_task_tick_dispatcher_unit_defines.svh
// assertion macros used by the tick dispatcher datapath
// no dependencies; define ASSERT_OFF to compile the checks away
`ifndef PERIODIC_TASK_TICK_DISPATCHER_UNIT_DEFINES_SVH
`define PERIODIC_TASK_TICK_DISPATCHER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define PTD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ptd assertion failed");

// next-cycle implication
`define PTD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ptd assertion failed");

`else

`define PTD_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define PTD_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

>>> rtl/ptd_pkg.sv
// shared types and constants for the tick dispatcher
// no dependencies
package ptd_pkg;

    localparam int TASK_COUNT_DEF = 8;
    localparam int KIND_W         = 3;
    localparam int ID_W           = 3;
    localparam int CNT_W          = 16;

    localparam logic [KIND_W-1:0] KIND_TICK    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_CREATE  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SUSPEND = 3'd2;
    localparam logic [KIND_W-1:0] KIND_RESUME  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DELETE  = 3'd4;

    // controller to datapath
    typedef struct packed {
        logic apply;
        logic start;
        logic advance;
        logic rd_en;
        logic eval_en;
        logic flush_en;
    } ptd_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic slot_active;
        logic idx_last;
        logic eval_stall;
        logic pend_valid;
        logic out_free;
    } ptd_sts_t;

endpackage

>>> rtl/ptd_req_if.sv
// request channel of the tick dispatcher: command or tick
// depends on ptd_pkg
interface ptd_req_if
    import ptd_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   task_id;
    logic [CNT_W-1:0]  period;
    logic [CNT_W-1:0]  first_delay;

    modport source (output valid, kind, task_id, period, first_delay, input ready);
    modport sink   (input valid, kind, task_id, period, first_delay, output ready);
endinterface

>>> rtl/ptd_rsp_if.sv
// result channel of the tick dispatcher: one fired slot per transfer
// depends on ptd_pkg
interface ptd_rsp_if
    import ptd_pkg::*;
;
    logic            valid;
    logic            ready;
    logic [ID_W-1:0] fired_task;
    logic            last;

    modport source (output valid, fired_task, last, input ready);
    modport sink   (input valid, fired_task, last, output ready);
endinterface

>>> rtl/ptd_ctrl.sv
// controller state machine: command handling and the slot walk of a tick
// depends on ptd_pkg
module ptd_ctrl
    import ptd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    input  logic      req_is_tick,
    output logic      req_ready,
    input  ptd_sts_t  sts,
    output ptd_cmd_t  cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_READ  = 2'd1;
    localparam logic [1:0] S_EVAL  = 2'd2;
    localparam logic [1:0] S_FLUSH = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       accept;

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.apply = accept && !req_is_tick;
                if (accept && req_is_tick)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                if (sts.slot_active)
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_EVAL;
                end
                else if (sts.idx_last)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    cmd.advance = 1'b1;
                end
            end
            S_EVAL:
            begin
                if (!sts.eval_stall)
                begin
                    cmd.eval_en = 1'b1;
                    if (sts.idx_last)
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                        state_next  = S_READ;
                    end
                end
            end
            S_FLUSH:
            begin
                cmd.flush_en = 1'b1;
                if (!sts.pend_valid || sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/ptd_datapath.sv
// slot table, countdown update, pending fired slot and output register
// depends on ptd_pkg and the assertion macro header
`include "periodic_task_tick_dispatcher_unit_defines.svh"

module ptd_datapath
    import ptd_pkg::*;
#(
    parameter int TASK_COUNT = TASK_COUNT_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  ptd_cmd_t          cmd,
    output ptd_sts_t          sts,
    input  logic [KIND_W-1:0] kind,
    input  logic [ID_W-1:0]   task_id,
    input  logic [CNT_W-1:0]  period,
    input  logic [CNT_W-1:0]  first_delay,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [ID_W-1:0]   fired_task,
    output logic              last
);

    localparam int IDX_W = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;

    logic [2*CNT_W-1:0]    slot_mem [TASK_COUNT];
    logic [2*CNT_W-1:0]    rdata_reg;
    logic [TASK_COUNT-1:0] present_reg;
    logic [TASK_COUNT-1:0] present_next;
    logic [TASK_COUNT-1:0] ready_reg;
    logic [TASK_COUNT-1:0] ready_next;
    logic [IDX_W-1:0]      idx_reg;
    logic [IDX_W-1:0]      idx_next;
    logic                  pend_valid_reg;
    logic                  pend_valid_next;
    logic [IDX_W-1:0]      pend_idx_reg;
    logic [IDX_W-1:0]      pend_idx_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [ID_W-1:0]       out_task_reg;
    logic                  out_last_reg;

    logic [IDX_W-1:0]      cmd_idx;
    logic                  id_ok;
    logic                  apply_ok;
    logic [CNT_W-1:0]      rd_period;
    logic [CNT_W-1:0]      rd_count;
    logic [CNT_W-1:0]      new_count;
    logic                  fire;
    logic                  out_free;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [2*CNT_W-1:0]    wr_data;
    logic                  push_en;
    logic [IDX_W-1:0]      push_idx;
    logic                  push_last;

    assign cmd_idx   = IDX_W'(task_id);
    assign id_ok     = (32'(task_id) < TASK_COUNT);
    assign apply_ok  = cmd.apply && id_ok;

    assign rd_period = rdata_reg[2*CNT_W-1:CNT_W];
    assign rd_count  = rdata_reg[CNT_W-1:0];
    assign fire      = (rd_count == '0);
    // reload wraps for a zero period
    assign new_count = fire ? (rd_period - CNT_W'(1)) : (rd_count - CNT_W'(1));
    assign out_free  = !out_valid_reg || out_ready;

    assign sts.slot_active = present_reg[idx_reg] && ready_reg[idx_reg];
    assign sts.idx_last    = (idx_reg == IDX_W'(TASK_COUNT - 1));
    assign sts.eval_stall  = fire && pend_valid_reg && !out_free;
    assign sts.pend_valid  = pend_valid_reg;
    assign sts.out_free    = out_free;

    assign wr_en   = (apply_ok && (kind == KIND_CREATE)) || cmd.eval_en;
    assign wr_addr = cmd.eval_en ? idx_reg : cmd_idx;
    assign wr_data = cmd.eval_en ? {rd_period, new_count} : {period, first_delay};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= slot_mem[idx_reg];
        end
    end

    // slot flags
    always_comb
    begin
        present_next = present_reg;
        ready_next   = ready_reg;
        if (apply_ok)
        begin
            case (kind)
                KIND_CREATE:
                begin
                    present_next[cmd_idx] = 1'b1;
                    ready_next[cmd_idx]   = 1'b1;
                end
                KIND_SUSPEND: ready_next[cmd_idx]   = 1'b0;
                KIND_RESUME:  ready_next[cmd_idx]   = 1'b1;
                KIND_DELETE:  present_next[cmd_idx] = 1'b0;
                default:      present_next = present_reg;
            endcase
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.start)
        begin
            idx_next = '0;
        end
        else if (cmd.advance)
        begin
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    // one fired slot is held back until the next one or the end of the walk
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        push_en         = 1'b0;
        push_idx        = pend_idx_reg;
        push_last       = 1'b0;
        if (cmd.eval_en && fire)
        begin
            push_en         = pend_valid_reg;
            pend_valid_next = 1'b1;
            pend_idx_next   = idx_reg;
        end
        else if (cmd.flush_en && pend_valid_reg && out_free)
        begin
            push_en         = 1'b1;
            push_last       = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (push_en)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg    <= '0;
            ready_reg      <= '0;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            present_reg    <= present_next;
            ready_reg      <= ready_next;
            idx_reg        <= idx_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg <= pend_idx_next;
        if (push_en)
        begin
            out_task_reg <= ID_W'(push_idx);
            out_last_reg <= push_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign fired_task = out_task_reg;
    assign last       = out_last_reg;

    `PTD_ASSERT_IMP(a_eval_not_stalled, clk, rst_n, cmd.eval_en, !sts.eval_stall)
    `PTD_ASSERT_NXT(a_fire_held, clk, rst_n, cmd.eval_en && fire,
                    pend_valid_reg && (pend_idx_reg == $past(idx_reg)))
    `PTD_ASSERT_NXT(a_flush_drains, clk, rst_n, cmd.flush_en && out_free, !pend_valid_reg)
    `PTD_ASSERT_NXT(a_create_sets, clk, rst_n, apply_ok && (kind == KIND_CREATE),
                    present_reg[$past(cmd_idx)] && ready_reg[$past(cmd_idx)])

endmodule

>>> rtl/periodic_task_tick_dispatcher_unit.sv
// tick dispatcher for a time-triggered cooperative scheduler
// request channel in: create, suspend, resume, delete or tick for one task slot
// result channel out: index of each slot that fires on a tick, last on the final one
// create/suspend/resume/delete are applied as they are accepted and give no result
// a tick walks the slots in ascending order, one step per cycle while the result
// channel does not stall: a slot that is not present and ready is skipped, an
// active slot takes a registered read of the slot table, then reload or decrement
// and write back; after the last slot a flush step releases the final fired
// index, and then the dispatcher returns to idle
// the slot table port and this walk set the rate; requests wait while it runs
// fired indices leave through an output register, one index is held back until
// the next firing or the end of the walk so that last can be set
// a stalled result channel pauses the walk; nothing is dropped
// reset clears the present and ready flags of all slots and returns to idle;
// the period and countdown table holds no reset and is only read for slots
// that a create has made present
// depends on ptd_pkg, ptd_req_if, ptd_rsp_if, ptd_ctrl, ptd_datapath
module periodic_task_tick_dispatcher_unit
    import ptd_pkg::*;
#(
    parameter int TASK_COUNT = TASK_COUNT_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    ptd_req_if.sink    req,
    ptd_rsp_if.source  rsp
);

    ptd_cmd_t cmd;
    ptd_sts_t sts;
    logic     req_ready;

    assign req.ready = req_ready;

    ptd_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req.valid),
        .req_is_tick (req.kind == KIND_TICK),
        .req_ready   (req_ready),
        .sts         (sts),
        .cmd         (cmd)
    );

    ptd_datapath #(
        .TASK_COUNT (TASK_COUNT)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .kind        (req.kind),
        .task_id     (req.task_id),
        .period      (req.period),
        .first_delay (req.first_delay),
        .out_valid   (rsp.valid),
        .out_ready   (rsp.ready),
        .fired_task  (rsp.fired_task),
        .last        (rsp.last)
    );

endmodule

>>> bench/tb_periodic_task_tick_dispatcher_unit.sv
// self-checking bench for the periodic task tick dispatcher: a directed table, then random
// commands and ticks, each result checked in order against a row's fire mask or a built-in slot-table predictor
// depends on ptd_pkg, ptd_req_if, ptd_rsp_if and periodic_task_tick_dispatcher_unit
module tb_periodic_task_tick_dispatcher_unit;
    import ptd_pkg::*;

    localparam int SLOTS = TASK_COUNT_DEF;
    localparam int RANDOM_REQUESTS = 350;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 4 * (2 * SLOTS + 1);
    localparam int MAX_REPORTS = 10;
    localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 3'd5;
    localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   task_id;
        logic [CNT_W-1:0]  period;
        logic [CNT_W-1:0]  first_delay;
    } request_t;

    typedef struct packed {
        logic [ID_W-1:0] fired_task;
        logic            last;
    } fired_t;

    typedef struct {
        request_t   req;
        bit         typed;
        bit [7:0]   fire_mask;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n;

    ptd_req_if req_ch();
    ptd_rsp_if rsp_ch();

    periodic_task_tick_dispatcher_unit u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor copy of the slot table
    logic [CNT_W-1:0] mdl_period [SLOTS];
    logic [CNT_W-1:0] mdl_count  [SLOTS];
    bit               mdl_present [SLOTS];
    bit               mdl_ready   [SLOTS];

    fired_t   due_q [$];
    dir_row_t dir_rows [$];
    int       mismatches = 0;
    bit       calm = 1'b0;
    bit       hold_req = 1'b0;
    bit       hold_taken = 1'b0;
    int       hold_left = 0;

    function automatic void schedule_step(request_t r, bit emit);
        fired_t hits [$];
        fired_t f;
        if (r.kind == KIND_TICK)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                if (mdl_present[i] && mdl_ready[i])
                begin
                    if (mdl_count[i] == '0)
                    begin
                        mdl_count[i] = mdl_period[i] - 16'd1;
                        f.fired_task = i[ID_W-1:0];
                        f.last = 1'b0;
                        hits.push_back(f);
                    end
                    else
                    begin
                        mdl_count[i] = mdl_count[i] - 16'd1;
                    end
                end
            end
            if (hits.size() > 0)
                hits[hits.size()-1].last = 1'b1;
            if (emit)
                foreach (hits[k])
                    due_q.push_back(hits[k]);
        end
        else if (int'(r.task_id) < SLOTS)
        begin
            case (r.kind)
                KIND_CREATE:
                begin
                    mdl_period[r.task_id] = r.period;
                    mdl_count[r.task_id] = r.first_delay;
                    mdl_ready[r.task_id] = 1'b1;
                    mdl_present[r.task_id] = 1'b1;
                end
                KIND_SUSPEND: mdl_ready[r.task_id] = 1'b0;
                KIND_RESUME:  mdl_ready[r.task_id] = 1'b1;
                KIND_DELETE:  mdl_present[r.task_id] = 1'b0;
                default: ;
            endcase
        end
    endfunction

    function automatic void add_row(logic [KIND_W-1:0] kind, int id, int period, int delay,
                                    bit typed, bit [7:0] fire_mask);
        dir_row_t row;
        row.req.kind = kind;
        row.req.task_id = id[ID_W-1:0];
        row.req.period = period[CNT_W-1:0];
        row.req.first_delay = delay[CNT_W-1:0];
        row.typed = typed;
        row.fire_mask = fire_mask;
        dir_rows.push_back(row);
    endfunction

    // typed expectation: fired slots in ascending order, last on the highest
    function automatic void push_mask(bit [7:0] fire_mask);
        fired_t f;
        int top;
        top = -1;
        for (int i = 0; i < 8; i++)
            if (fire_mask[i])
                top = i;
        for (int i = 0; i < 8; i++)
        begin
            if (fire_mask[i])
            begin
                f.fired_task = i[ID_W-1:0];
                f.last = (i == top);
                due_q.push_back(f);
            end
        end
    endfunction

    task automatic send_request(request_t r, bit typed, bit [7:0] fire_mask);
        while (!calm && $urandom_range(99) < 23)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.kind <= r.kind;
        req_ch.task_id <= r.task_id;
        req_ch.period <= r.period;
        req_ch.first_delay <= r.first_delay;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        if (typed)
        begin
            push_mask(fire_mask);
            schedule_step(r, 1'b0);
        end
        else
        begin
            schedule_step(r, 1'b1);
        end
    endtask

    function automatic logic [CNT_W-1:0] pick_count();
        int roll;
        roll = $urandom_range(99);
        if (roll < 10)
            return CNT_W'($urandom_range(65535));
        else if (roll < 13)
            return '0;
        else
            return CNT_W'($urandom_range(4, 1));
    endfunction

    function automatic request_t random_request();
        request_t r;
        int roll;
        roll = $urandom_range(99);
        r.task_id = ID_W'($urandom_range(SLOTS - 1));
        r.period = CNT_W'($urandom_range(65535));
        r.first_delay = CNT_W'($urandom_range(65535));
        if (roll < 40)
            r.kind = KIND_TICK;
        else if (roll < 65)
        begin
            r.kind = KIND_CREATE;
            r.period = pick_count();
            r.first_delay = pick_count() - 16'd1;
            if (r.first_delay > 16'd3 && $urandom_range(3) != 0)
                r.first_delay = CNT_W'($urandom_range(3));
        end
        else if (roll < 75)
            r.kind = KIND_SUSPEND;
        else if (roll < 85)
            r.kind = KIND_RESUME;
        else if (roll < 93)
            r.kind = KIND_DELETE;
        else
            r.kind = KIND_W'($urandom_range(KIND_UNUSED_HI, KIND_UNUSED_LO));
        return r;
    endfunction

    // result sink with random stalls and one long hold-off
    initial
    begin
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= calm || ($urandom_range(99) >= 23);
            end
        end
    end

    always @(posedge clk)
    begin
        fired_t got;
        fired_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got.fired_task = rsp_ch.fired_task;
            got.last = rsp_ch.last;
            if (due_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: fired_task=%0d last=%0d",
                             got.fired_task, got.last);
            end
            else
            begin
                want = due_q.pop_front();
                if (got.fired_task !== want.fired_task || got.last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"mismatch: expected fired_task=%0d last=%0d,",
                                  " got fired_task=%0d last=%0d"},
                                 want.fired_task, want.last, got.fired_task, got.last);
                end
            end
        end
    end

    initial
    begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        request_t r;
        int sent;
        rst_n <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.kind <= KIND_TICK;
        req_ch.task_id <= '0;
        req_ch.period <= '0;
        req_ch.first_delay <= '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            mdl_period[i] = '0;
            mdl_count[i] = '0;
            mdl_present[i] = 1'b0;
            mdl_ready[i] = 1'b0;
        end

        // tick after reset, extremes of period and delay, zero period wrap,
        // suspend/resume, overwrite, commands on absent slots, unused kinds
        add_row(KIND_TICK,      0, 0,     0,     1, 8'h00);
        add_row(KIND_UNUSED_LO, 0, 0,     0,     1, 8'h00);
        add_row(KIND_CREATE,    0, 1,     0,     0, 8'h00);
        add_row(KIND_CREATE,    7, 0,     0,     0, 8'h00);
        add_row(KIND_CREATE,    3, 65535, 65535, 0, 8'h00);
        add_row(KIND_TICK,      0, 0,     0,     1, 8'h81);
        add_row(KIND_TICK,      0, 0,     0,     1, 8'h01);
        add_row(KIND_SUSPEND,   0, 0,     0,     0, 8'h00);
        add_row(KIND_TICK,      0, 0,     0,     1, 8'h00);
        add_row(KIND_RESUME,    0, 0,     0,     0, 8'h00);
        add_row(KIND_CREATE,    3, 2,     1,     0, 8'h00);
        add_row(KIND_TICK,      0, 0,     0,     1, 8'h01);
        add_row(KIND_TICK,      0, 0,     0,     1, 8'h09);
        add_row(KIND_DELETE,    0, 0,     0,     0, 8'h00);
        add_row(KIND_SUSPEND,   5, 0,     0,     0, 8'h00);
        add_row(KIND_RESUME,    5, 0,     0,     0, 8'h00);
        add_row(KIND_DELETE,    5, 0,     0,     0, 8'h00);
        add_row(KIND_UNUSED_HI, 7, 65535, 65535, 1, 8'h00);
        add_row(KIND_TICK,      0, 0,     0,     1, 8'h00);
        add_row(KIND_CREATE,    5, 3,     0,     0, 8'h00);
        add_row(KIND_RESUME,    0, 0,     0,     0, 8'h00);
        add_row(KIND_TICK,      0, 0,     0,     1, 8'h28);
        add_row(KIND_CREATE,    0, 65535, 0,     0, 8'h00);
        add_row(KIND_TICK,      0, 0,     0,     1, 8'h01);
        add_row(KIND_TICK,      0, 0,     0,     0, 8'h00);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[k])
            send_request(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].fire_mask);

        sent = 0;
        while (sent < RANDOM_REQUESTS)
        begin
            if (sent >= 100 && !hold_req)
                hold_req <= 1'b1;
            calm <= (sent >= 200 && sent < 260);
            if ($urandom_range(99) < 3)
            begin
                // every slot due at once: a full tick of results
                for (int i = 0; i < SLOTS; i++)
                begin
                    r.kind = KIND_CREATE;
                    r.task_id = i[ID_W-1:0];
                    r.period = 16'd1;
                    r.first_delay = '0;
                    send_request(r, 1'b0, 8'h00);
                end
                r = '0;
                r.kind = KIND_TICK;
                send_request(r, 1'b0, 8'h00);
                send_request(r, 1'b0, 8'h00);
                sent += SLOTS + 2;
            end
            else
            begin
                r = random_request();
                send_request(r, 1'b0, 8'h00);
                sent++;
            end
        end
        req_ch.valid <= 1'b0;
        calm <= 1'b0;

        while (due_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && due_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
